// ===== hdl/bmsp_pkg.sv =====
// Package for the binned mean / standard error profile block.
// Holds widths, reset values, register codes, payload and state types.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package bmsp_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int COUNT_WIDTH  = 16;
  localparam int MAX_BINS_DEF = 16;
  localparam int SUM_W        = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int SQR_W        = 2 * SAMPLE_WIDTH - 1;
  localparam int SQ_W         = 64;
  localparam int ACC_W        = COUNT_WIDTH + SQ_W;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int OFF_W        = SAMPLE_WIDTH;
  localparam int WID_W        = SAMPLE_WIDTH - 1;
  localparam int ERR_W        = SAMPLE_WIDTH - 1;
  localparam int NB_W         = 5;
  localparam int BINNUM_W     = 4;
  localparam int MAX_RESULTS  = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int DIV_PASSES   = 3;

  localparam logic signed [SAMPLE_WIDTH-1:0] START_RST = '0;
  localparam logic [WID_W-1:0]               WIDTH_RST = WID_W'(20480);
  localparam logic [NB_W-1:0]                NB_RST    = NB_W'(14);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_START = 2'd0,
    CFG_BIN_WIDTH = 2'd1,
    CFG_NUM_BINS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x_value;
    logic signed [SAMPLE_WIDTH-1:0] y_value;
    logic                           last_point;
  } in_t;

  typedef struct packed {
    logic [BINNUM_W-1:0]            bin_number;
    logic                           bin_valid;
    logic [COUNT_WIDTH-1:0]         point_count;
    logic signed [SAMPLE_WIDTH-1:0] x_mean;
    logic signed [SAMPLE_WIDTH-1:0] y_mean;
    logic [ERR_W-1:0]               x_error;
    logic [ERR_W-1:0]               y_error;
    logic                           count_saturated;
    logic                           last_result;
  } result_t;

  // One point travelling down the row of bin cells.
  typedef struct packed {
    logic                           valid;
    logic [OFF_W-1:0]               off;
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic [SQR_W-1:0]               xsq;
    logic [SQR_W-1:0]               ysq;
  } point_t;

  // Accumulated state of one bin.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0]  count;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [SQ_W-1:0]         sumsq_x;
    logic [SQ_W-1:0]         sumsq_y;
    logic                    ovf;
  } bin_state_t;

  typedef struct packed {
    logic [BINNUM_W-1:0] bin_number;
    bin_state_t          st;
  } stat_req_t;

  typedef enum logic [2:0] {
    TS_RUN, TS_DRAIN, TS_PICK, TS_CALC, TS_FINAL
  } top_state_t;

  typedef enum logic [2:0] {
    ES_IDLE, ES_SETUP, ES_MEAN, ES_MULA, ES_MULB, ES_DIV, ES_ROOT, ES_DONE
  } eng_state_t;

endpackage

// ===== hdl/binned_mean_stderr_profile.sv =====
// Binned profile block: per-bin mean and standard error of (x, y) points.
// Depends on bmsp_pkg, bmsp_cell and bmsp_stat.
//
// Usage. A point item is taken at a rising edge with start high and busy
// low. Points enter a row of MAX_BINS bin cells; each cell checks whether
// the point lies in its bin, accumulates it or registers it and passes it on.
// A new point can be taken in every cycle while no data set is closing.
// The item with last_point set is taken in like any other and then closes
// the data set: busy rises, the row drains, and the cells shift their bins
// out toward the statistics engine, one bin a cycle while the engine is not
// busy with a bin. In the engine each non-empty bin gets, for x and for y,
// a mean division, a multiply-subtract and, if its result is positive,
// three divisions and then, unless the quotient is too wide, a root.
// Results leave on out_data, each marked by out_valid for one cycle; the
// receiver has no way to stall them. The last result carries last_result.
// Shifting the bins out leaves every cell cleared for the next data set.
// The configuration port is ready only while no data set is closing, no
// point is still in the row and no point is being offered on start. Reset
// clears every bin and loads the register defaults: start 0.0, width 5.0,
// fourteen bins.
module binned_mean_stderr_profile #(
  parameter int MAX_BINS = bmsp_pkg::MAX_BINS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  bmsp_pkg::in_t                        in_data,
  output logic                                 out_valid,
  output bmsp_pkg::result_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bmsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmsp_pkg::SAMPLE_WIDTH-1:0]    cfg_data
);

  localparam int SW    = bmsp_pkg::SAMPLE_WIDTH;
  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NO_W  = $clog2(bmsp_pkg::MAX_RESULTS + 1);

  // Configuration registers.
  logic signed [SW-1:0]          start_r;
  logic [bmsp_pkg::WID_W-1:0]    width_r;
  logic [bmsp_pkg::NB_W-1:0]     num_bins_r;

  // Control.
  bmsp_pkg::top_state_t  state_r, state_nxt;
  logic [IDX_W-1:0]      bin_idx_r, bin_idx_nxt;
  logic                  end_r, end_nxt;
  logic [NO_W-1:0]       n_load_r, n_load_nxt;
  logic                  pend_v_r, pend_v_nxt;
  bmsp_pkg::result_t     pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  bmsp_pkg::result_t     out_data_r, out_data_nxt;

  logic                  accept;
  logic                  at_last;
  logic                  load;
  logic                  shift_en;
  logic                  chain_busy;
  logic                  eng_done;
  bmsp_pkg::result_t     eng_res;
  bmsp_pkg::stat_req_t   eng_req;

  // Entry stage of the row.
  bmsp_pkg::point_t      ent_r, ent_nxt;
  logic signed [SW:0]    off_full;
  logic [SW-1:0]         ax;
  logic [SW-1:0]         ay;

  bmsp_pkg::point_t      pt_chain [0:MAX_BINS];
  bmsp_pkg::bin_state_t  st_chain [0:MAX_BINS];
  logic [MAX_BINS:0]     vld;

  assign accept  = start && !busy;
  assign busy    = state_r != bmsp_pkg::TS_RUN;
  assign at_last = bin_idx_r == IDX_W'(MAX_BINS - 1);
  assign load    = (state_r == bmsp_pkg::TS_PICK) && (st_chain[0].count != '0)
                   && (n_load_r < NO_W'(bmsp_pkg::MAX_RESULTS));
  assign shift_en   = state_r == bmsp_pkg::TS_PICK;
  assign chain_busy = |vld;
  assign cfg_ready  = !busy && !chain_busy && !start;

  // The offset from the first bin edge decides whether the point is kept at
  // all; each cell then takes one bin width off as the point walks along.
  always_comb begin
    off_full      = {in_data.x_value[SW-1], in_data.x_value} - {start_r[SW-1], start_r};
    ax            = in_data.x_value[SW-1] ? SW'(-in_data.x_value) : SW'(in_data.x_value);
    ay            = in_data.y_value[SW-1] ? SW'(-in_data.y_value) : SW'(in_data.y_value);
    ent_nxt.valid = accept && !off_full[SW] && (width_r != '0);
    ent_nxt.off   = off_full[SW-1:0];
    ent_nxt.x     = in_data.x_value;
    ent_nxt.y     = in_data.y_value;
    ent_nxt.xsq   = bmsp_pkg::SQR_W'(ax * ax);
    ent_nxt.ysq   = bmsp_pkg::SQR_W'(ay * ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign pt_chain[0]        = ent_r;
  assign st_chain[MAX_BINS] = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_BINS; k++) begin : g_cell
      logic en;
      assign en = int'(num_bins_r) > k;
      bmsp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (en),
        .width_in  (width_r),
        .shift_en  (shift_en),
        .pt_in     (pt_chain[k]),
        .st_in     (st_chain[k+1]),
        .pt_out    (pt_chain[k+1]),
        .st_out    (st_chain[k])
      );
    end
    for (k = 0; k <= MAX_BINS; k++) begin : g_vld
      assign vld[k] = pt_chain[k].valid;
    end
  endgenerate

  assign eng_req = {bmsp_pkg::BINNUM_W'(bin_idx_r), st_chain[0]};

  bmsp_stat u_stat (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load),
    .req   (eng_req),
    .done  (eng_done),
    .res   (eng_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmsp_pkg::TS_RUN: begin
        if (accept && in_data.last_point) state_nxt = bmsp_pkg::TS_DRAIN;
      end
      bmsp_pkg::TS_DRAIN: begin
        if (!chain_busy) state_nxt = bmsp_pkg::TS_PICK;
      end
      bmsp_pkg::TS_PICK: begin
        if (load)         state_nxt = bmsp_pkg::TS_CALC;
        else if (at_last) state_nxt = bmsp_pkg::TS_FINAL;
      end
      bmsp_pkg::TS_CALC: begin
        if (eng_done) state_nxt = end_r ? bmsp_pkg::TS_FINAL : bmsp_pkg::TS_PICK;
      end
      bmsp_pkg::TS_FINAL: state_nxt = bmsp_pkg::TS_RUN;
      default: state_nxt = bmsp_pkg::TS_RUN;
    endcase
  end

  // Outputs and bookkeeping. A finished bin is held back until the next one
  // is known, so that the final result can be marked as such.
  always_comb begin
    bin_idx_nxt   = bin_idx_r;
    end_nxt       = end_r;
    n_load_nxt    = n_load_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      bmsp_pkg::TS_RUN: begin
        bin_idx_nxt = '0;
        n_load_nxt  = '0;
        pend_v_nxt  = 1'b0;
      end
      bmsp_pkg::TS_PICK: begin
        bin_idx_nxt = bin_idx_r + 1'b1;
        end_nxt     = at_last;
        if (load) n_load_nxt = n_load_r + 1'b1;
      end
      bmsp_pkg::TS_CALC: begin
        if (eng_done) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pend_r;
          end
          pend_nxt   = eng_res;
          pend_v_nxt = 1'b1;
        end
      end
      bmsp_pkg::TS_FINAL: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt             = pend_v_r ? pend_r : '0;
        out_data_nxt.last_result = 1'b1;
        pend_v_nxt               = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    bin_idx_r  <= bin_idx_nxt;
    end_r      <= end_nxt;
    n_load_r   <= n_load_nxt;
    if (!rst_n) begin
      state_r     <= bmsp_pkg::TS_RUN;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= bmsp_pkg::START_RST;
      width_r     <= bmsp_pkg::WIDTH_RST;
      num_bins_r  <= bmsp_pkg::NB_RST;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (bmsp_pkg::cfg_reg_t'(cfg_index))
          bmsp_pkg::CFG_BIN_START: start_r    <= cfg_data;
          bmsp_pkg::CFG_BIN_WIDTH: width_r    <= cfg_data[bmsp_pkg::WID_W-1:0];
          bmsp_pkg::CFG_NUM_BINS:  num_bins_r <= cfg_data[bmsp_pkg::NB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.bin_valid |-> out_data_r.last_result)
    else $error("empty-run result not marked last");

  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_result |=> !out_valid_r)
    else $error("result right after the final result");

  a_shift_clears_tail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bmsp_pkg::TS_PICK |=> st_chain[MAX_BINS-1] == '0)
    else $error("tail cell not cleared by read-out shift");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> state_r == bmsp_pkg::TS_CALC)
    else $error("engine finished outside the calculation phase");
`endif

endmodule

// ===== hdl/bmsp_cell.sv =====
// One bin cell of the profile row: claims points that fall into its bin,
// passes the rest on if enabled, and shifts its state toward the head on read-out.
// Depends on bmsp_pkg.
module bmsp_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              enable,
  input  logic [bmsp_pkg::WID_W-1:0]        width_in,
  input  logic                              shift_en,
  input  bmsp_pkg::point_t                  pt_in,
  input  bmsp_pkg::bin_state_t              st_in,
  output bmsp_pkg::point_t                  pt_out,
  output bmsp_pkg::bin_state_t              st_out
);

  bmsp_pkg::point_t     pt_r, pt_nxt;
  bmsp_pkg::bin_state_t st_r, st_nxt;
  logic                 above;
  logic                 hit;

  assign above = pt_in.off >= bmsp_pkg::OFF_W'(width_in);
  assign hit   = pt_in.valid && enable && !above;

  always_comb begin
    pt_nxt       = pt_in;
    pt_nxt.valid = pt_in.valid && enable && above;
    pt_nxt.off   = pt_in.off - bmsp_pkg::OFF_W'(width_in);
    st_nxt       = st_r;
    if (shift_en) begin
      st_nxt = st_in;
    end else if (hit) begin
      if (st_r.count == '1) begin
        st_nxt.ovf = 1'b1;
      end else begin
        st_nxt.count   = st_r.count + 1'b1;
        st_nxt.sum_x   = st_r.sum_x + bmsp_pkg::SUM_W'(pt_in.x);
        st_nxt.sum_y   = st_r.sum_y + bmsp_pkg::SUM_W'(pt_in.y);
        st_nxt.sumsq_x = st_r.sumsq_x + bmsp_pkg::SQ_W'(pt_in.xsq);
        st_nxt.sumsq_y = st_r.sumsq_y + bmsp_pkg::SQ_W'(pt_in.ysq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= '0;
      st_r <= '0;
    end else begin
      pt_r <= pt_nxt;
      st_r <= st_nxt;
    end
  end

  assign pt_out = pt_r;
  assign st_out = st_r;

endmodule

// ===== hdl/bmsp_stat.sv =====
// Statistics engine: mean and standard error of one bin, x then y, with a
// shared bit-serial divider, shift-add multiplier and digit-by-digit root.
// Depends on bmsp_pkg.
module bmsp_stat (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  bmsp_pkg::stat_req_t   req,
  output logic                  done,
  output bmsp_pkg::result_t     res
);

  localparam int CW    = bmsp_pkg::COUNT_WIDTH;
  localparam int SW    = bmsp_pkg::SAMPLE_WIDTH;
  localparam int SUMW  = bmsp_pkg::SUM_W;
  localparam int SQW   = bmsp_pkg::SQ_W;
  localparam int AW    = bmsp_pkg::ACC_W;
  localparam int RW    = bmsp_pkg::ROOT_W;
  localparam int EW    = bmsp_pkg::ERR_W;
  localparam int CNT_W = $clog2(AW);

  bmsp_pkg::eng_state_t st_r, st_nxt;
  bmsp_pkg::eng_state_t chan_end;
  bmsp_pkg::stat_req_t  req_r, req_nxt;
  bmsp_pkg::result_t    res_r, res_nxt;
  logic                 ch_r, ch_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           pass_r, pass_nxt;
  logic signed [AW:0]   acc_r, acc_nxt;
  logic [AW-1:0]        mcand_r, mcand_nxt;
  logic [SUMW-1:0]      mplier_r, mplier_nxt;
  logic [AW-1:0]        quo_r, quo_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [RW-1:0]        root_r, root_nxt;
  logic [RW+1:0]        rrem_r, rrem_nxt;

  logic [CW-1:0]          n_cur;
  logic signed [SUMW-1:0] s1;
  logic [SQW-1:0]         s2;
  logic                   neg;
  logic [SUMW-1:0]        mag;
  logic [CW:0]            rem_sh;
  logic                   div_ge;
  logic [AW-1:0]          quo_step;
  logic [CW-1:0]          rem_step;
  logic signed [AW:0]     mterm;
  logic signed [AW:0]     acc_add;
  logic signed [AW:0]     acc_sub;
  logic                   acc_pos;
  logic [RW+3:0]          rr;
  logic [RW+3:0]          trial;
  logic                   root_ge;
  logic [RW-1:0]          root_step;
  logic [SW-1:0]          mean_q;
  logic                   div_last;
  logic                   mula_last;
  logic                   mulb_last;
  logic                   root_last;
  logic                   root_big;

  assign n_cur  = req_r.st.count;
  assign s1     = ch_r ? req_r.st.sum_y : req_r.st.sum_x;
  assign s2     = ch_r ? req_r.st.sumsq_y : req_r.st.sumsq_x;
  assign neg    = s1[SUMW-1];
  assign mag    = neg ? SUMW'(-s1) : SUMW'(s1);

  // Restoring division step, one quotient bit per cycle.
  assign rem_sh   = {rem_r, quo_r[AW-1]};
  assign div_ge   = rem_sh >= {1'b0, n_cur};
  assign rem_step = div_ge ? CW'(rem_sh - {1'b0, n_cur}) : CW'(rem_sh);
  assign quo_step = {quo_r[AW-2:0], div_ge};

  assign mterm   = mplier_r[0] ? $signed({1'b0, mcand_r}) : '0;
  assign acc_add = acc_r + mterm;
  assign acc_sub = acc_r - mterm;
  assign acc_pos = !acc_sub[AW] && (acc_sub != '0);

  // Square root step on the two leading bits of the radicand.
  assign rr        = {rrem_r, quo_r[SQW-1 -: 2]};
  assign trial     = (RW+4)'({root_r, 2'b01});
  assign root_ge   = rr >= trial;
  assign root_step = {root_r[RW-2:0], root_ge};

  assign mean_q    = quo_step[SW-1:0];
  assign div_last  = cnt_r == CNT_W'(AW - 1);
  assign mula_last = cnt_r == CNT_W'(CW - 1);
  assign mulb_last = cnt_r == CNT_W'(SUMW - 1);
  assign root_last = cnt_r == CNT_W'(RW - 1);
  assign root_big  = |quo_step[AW-1:SQW];

  always_comb begin
    chan_end = ch_r ? bmsp_pkg::ES_DONE : bmsp_pkg::ES_SETUP;
    st_nxt   = st_r;
    unique case (st_r)
      bmsp_pkg::ES_IDLE: begin
        if (start) st_nxt = bmsp_pkg::ES_SETUP;
      end
      bmsp_pkg::ES_SETUP: st_nxt = bmsp_pkg::ES_MEAN;
      bmsp_pkg::ES_MEAN: begin
        if (div_last) st_nxt = bmsp_pkg::ES_MULA;
      end
      bmsp_pkg::ES_MULA: begin
        if (mula_last) st_nxt = bmsp_pkg::ES_MULB;
      end
      bmsp_pkg::ES_MULB: begin
        if (mulb_last) st_nxt = acc_pos ? bmsp_pkg::ES_DIV : chan_end;
      end
      bmsp_pkg::ES_DIV: begin
        if (div_last && pass_r == 2'(bmsp_pkg::DIV_PASSES - 1)) begin
          st_nxt = root_big ? chan_end : bmsp_pkg::ES_ROOT;
        end
      end
      bmsp_pkg::ES_ROOT: begin
        if (root_last) st_nxt = chan_end;
      end
      bmsp_pkg::ES_DONE: st_nxt = bmsp_pkg::ES_IDLE;
      default: st_nxt = bmsp_pkg::ES_IDLE;
    endcase
  end

  always_comb begin
    req_nxt    = req_r;
    res_nxt    = res_r;
    ch_nxt     = ch_r;
    cnt_nxt    = cnt_r + 1'b1;
    pass_nxt   = pass_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    rrem_nxt   = rrem_r;
    case (st_r)
      bmsp_pkg::ES_IDLE: begin
        req_nxt                 = req;
        ch_nxt                  = 1'b0;
        res_nxt                 = '0;
        res_nxt.bin_number      = req.bin_number;
        res_nxt.bin_valid       = 1'b1;
        res_nxt.point_count     = req.st.count;
        res_nxt.count_saturated = req.st.ovf;
      end
      bmsp_pkg::ES_SETUP: begin
        quo_nxt = AW'(mag);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      bmsp_pkg::ES_MEAN: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        if (div_last) begin
          if (ch_r) res_nxt.y_mean = neg ? SW'(-mean_q) : mean_q;
          else      res_nxt.x_mean = neg ? SW'(-mean_q) : mean_q;
          acc_nxt    = '0;
          mcand_nxt  = AW'(s2);
          mplier_nxt = SUMW'(n_cur);
          cnt_nxt    = '0;
        end
      end
      bmsp_pkg::ES_MULA: begin
        acc_nxt    = acc_add;
        mcand_nxt  = {mcand_r[AW-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        if (mula_last) begin
          mcand_nxt  = AW'(mag);
          mplier_nxt = mag;
          cnt_nxt    = '0;
        end
      end
      bmsp_pkg::ES_MULB: begin
        acc_nxt    = acc_sub;
        mcand_nxt  = {mcand_r[AW-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        if (mulb_last) begin
          quo_nxt  = acc_sub[AW-1:0];
          rem_nxt  = '0;
          pass_nxt = '0;
          cnt_nxt  = '0;
          if (!acc_pos) ch_nxt = 1'b1;
        end
      end
      bmsp_pkg::ES_DIV: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        if (div_last) begin
          pass_nxt = pass_r + 1'b1;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          root_nxt = '0;
          rrem_nxt = '0;
          if (pass_r == 2'(bmsp_pkg::DIV_PASSES - 1) && root_big) begin
            if (ch_r) res_nxt.y_error = '1;
            else      res_nxt.x_error = '1;
            ch_nxt = 1'b1;
          end
        end
      end
      bmsp_pkg::ES_ROOT: begin
        root_nxt = root_step;
        rrem_nxt = root_ge ? (RW+2)'(rr - trial) : (RW+2)'(rr);
        quo_nxt  = {quo_r[AW-3:0], 2'b00};
        if (root_last) begin
          if (root_step > RW'({EW{1'b1}})) begin
            if (ch_r) res_nxt.y_error = '1;
            else      res_nxt.x_error = '1;
          end else begin
            if (ch_r) res_nxt.y_error = root_step[EW-1:0];
            else      res_nxt.x_error = root_step[EW-1:0];
          end
          ch_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    res_r    <= res_nxt;
    cnt_r    <= cnt_nxt;
    pass_r   <= pass_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    rrem_r   <= rrem_nxt;
    if (!rst_n) begin
      st_r <= bmsp_pkg::ES_IDLE;
      ch_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ch_r <= ch_nxt;
    end
  end

  assign done = st_r == bmsp_pkg::ES_DONE;
  assign res  = res_r;

endmodule
